/* rtl/nrmc_pkg.sv */
// Package for the RMC sentence parser: character codes, field numbers,
// per-field scaling and saturation constants.
// No dependencies.
package nrmc_pkg;

  // Character codes used by the parser.
  localparam logic [7:0] ASCII_DOLLAR = 8'h24;
  localparam logic [7:0] ASCII_COMMA  = 8'h2C;
  localparam logic [7:0] ASCII_DOT    = 8'h2E;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_NINE   = 8'h39;
  localparam logic [7:0] ASCII_V      = 8'h56;

  // Header match positions. Values between these two count matched characters.
  localparam logic [2:0] HP_IDLE = 3'd0;
  localparam logic [2:0] HP_SYNC = 3'd1;
  localparam logic [2:0] HP_LAST = 3'd6;
  localparam logic [2:0] HP_BODY = 3'd7;

  // Field numbers within the sentence body.
  localparam logic [2:0] FLD_TIME   = 3'd0;
  localparam logic [2:0] FLD_STATUS = 3'd1;
  localparam logic [2:0] FLD_LAT    = 3'd2;
  localparam logic [2:0] FLD_LATDIR = 3'd3;
  localparam logic [2:0] FLD_LON    = 3'd4;
  localparam logic [2:0] FLD_LONDIR = 3'd5;
  localparam logic [2:0] FLD_SPEED  = 3'd6;
  localparam logic [2:0] FLD_TRACK  = 3'd7;

  // Output widths.
  localparam int LAT_W   = 27;
  localparam int LON_W   = 30;
  localparam int KNOTS_W = 20;
  localparam int SPEED_W = 31;
  localparam int TRACK_W = 17;
  localparam int ACC_W   = 30;

  // Saturation limits.
  localparam logic [ACC_W-1:0] ACC_CAP   = 30'd999999999;
  localparam logic [ACC_W-1:0] LAT_CAP   = 30'd99999999;
  localparam logic [ACC_W-1:0] LON_CAP   = 30'd999999999;
  localparam logic [ACC_W-1:0] SPEED_CAP = 30'd999999;
  localparam logic [ACC_W-1:0] TRACK_CAP = 30'd99999;

  // Knots to micro km/h.
  localparam logic [10:0] SPEED_FACTOR = 11'd1852;

  // Largest number of fraction digits any field keeps.
  localparam logic [2:0] MAX_FRAC = 3'd4;

  localparam int MAX_FIELD_CHARS_DEF = 11;

  // Expected header character at a given match position.
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd1:    c = 8'h47; // G
      3'd2:    c = 8'h50; // P
      3'd3:    c = 8'h52; // R
      3'd4:    c = 8'h4D; // M
      3'd5:    c = 8'h43; // C
      3'd6:    c = ASCII_COMMA;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Fraction digits kept by each numeric field.
  function automatic logic [2:0] frac_of(input logic [2:0] fld);
    logic [2:0] n;
    case (fld)
      FLD_LAT:   n = 3'd4;
      FLD_LON:   n = 3'd4;
      FLD_SPEED: n = 3'd3;
      FLD_TRACK: n = 3'd2;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  // Saturation limit of each numeric field.
  function automatic logic [ACC_W-1:0] cap_of(input logic [2:0] fld);
    logic [ACC_W-1:0] c;
    case (fld)
      FLD_LAT:   c = LAT_CAP;
      FLD_LON:   c = LON_CAP;
      FLD_SPEED: c = SPEED_CAP;
      FLD_TRACK: c = TRACK_CAP;
      default:   c = '0;
    endcase
    return c;
  endfunction

  // Power of ten for the missing fraction digits.
  function automatic logic [13:0] pow10(input logic [2:0] k);
    logic [13:0] p;
    case (k)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      3'd4:    p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

endpackage

/* rtl/nmea_rmc_sentence_parser_core.sv */
// RMC sentence parser: one received character per transfer, one fix result
// per complete (or void) sentence.
// Depends on nrmc_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  rx      | in        | rx_valid / rx_stall | rx_byte
//  res     | out       | res_valid/res_stall | fix_valid, lat_value, lat_hemisphere,
//          |           |                     | lon_value, lon_hemisphere,
//          |           |                     | speed_kmh_micro, track_centideg
//
// One character is taken in every cycle while rx_stall is low. A character is held in the input
// register while the parse logic works on it; a result it causes is then loaded into the
// result register, which raises res_valid, and the result transfer is made from there.
// The longest path runs from the accumulator and fraction counter through the fraction
// scaling multiply (accumulator times a power of ten) and the saturation compare.
// Reset (rst, synchronous) returns to waiting for a dollar sign and clears all
// held fix values; no clearing pass is needed.
// A stalled result holds the parse stage, which in turn stalls rx once the input
// register is full; nothing is lost or repeated.
module nmea_rmc_sentence_parser_core
  import nrmc_pkg::*;
#(
  parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               fix_valid,
  output logic [LAT_W-1:0]   lat_value,
  output logic [7:0]         lat_hemisphere,
  output logic [LON_W-1:0]   lon_value,
  output logic [7:0]         lon_hemisphere,
  output logic [SPEED_W-1:0] speed_kmh_micro,
  output logic [TRACK_W-1:0] track_centideg
);

  // Wide enough to hold MAX_FIELD_CHARS itself.
  localparam int CW = $clog2(MAX_FIELD_CHARS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FIELD_CHARS);

  // Input register.
  logic       byte_valid;
  logic [7:0] byte_q;

  // Parser state.
  logic [2:0]         hdr_pos, hdr_pos_next;
  logic [2:0]         fld, fld_next;
  logic [ACC_W-1:0]   acc, acc_next;
  logic [2:0]         seen, seen_next;
  logic               point, point_next;
  logic               stopped, stopped_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [LAT_W-1:0]   held_lat, held_lat_next;
  logic [7:0]         held_lat_hem, held_lat_hem_next;
  logic [LON_W-1:0]   held_lon, held_lon_next;
  logic [7:0]         held_lon_hem, held_lon_hem_next;
  logic [KNOTS_W-1:0] held_knots, held_knots_next;
  logic [TRACK_W-1:0] held_track, held_track_next;

  // Result register; speed is kept in thousandths of a knot and scaled on the way out.
  logic [KNOTS_W-1:0] res_knots;

  logic emit;
  logic emit_fix;
  logic advance;

  // The parse stage moves whenever a character is waiting and the result register is free or being emptied.
  assign advance  = byte_valid && !(res_valid && res_stall);
  assign rx_stall = byte_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!rx_stall) begin
      byte_valid <= rx_valid;
    end
    if (!rx_stall && rx_valid) begin
      byte_q <= rx_byte;
    end
  end

  // Number finishing: pad missing fraction digits with zeros, then saturate.
  logic [2:0]         frac_cur;
  logic [ACC_W-1:0]   cap_cur;
  logic [43:0]        scaled;
  logic [ACC_W-1:0]   finished;
  logic [33:0]        acc_mul;
  logic [ACC_W-1:0]   acc_digit;

  always_comb begin
    frac_cur  = frac_of(fld);
    cap_cur   = cap_of(fld);
    scaled    = 44'(acc) * 44'(pow10(frac_cur - seen));
    finished  = (scaled > 44'(cap_cur)) ? cap_cur : scaled[ACC_W-1:0];
    acc_mul   = (34'(acc) << 3) + (34'(acc) << 1) + 34'(4'(byte_q - ASCII_ZERO));
    acc_digit = (acc_mul > 34'(ACC_CAP)) ? ACC_CAP : acc_mul[ACC_W-1:0];
  end

  always_comb begin
    hdr_pos_next      = hdr_pos;
    fld_next          = fld;
    acc_next          = acc;
    seen_next         = seen;
    point_next        = point;
    stopped_next      = stopped;
    cnt_next          = cnt;
    held_lat_next     = held_lat;
    held_lat_hem_next = held_lat_hem;
    held_lon_next     = held_lon;
    held_lon_hem_next = held_lon_hem;
    held_knots_next   = held_knots;
    held_track_next   = held_track;
    emit              = 1'b0;
    emit_fix          = 1'b0;

    if (byte_q == ASCII_DOLLAR) begin
      // A dollar sign always restarts the header match.
      hdr_pos_next = HP_SYNC;
      fld_next     = FLD_TIME;
      acc_next     = '0;
      seen_next    = '0;
      point_next   = 1'b0;
      stopped_next = 1'b0;
      cnt_next     = '0;
    end else if (hdr_pos == HP_IDLE) begin
      // Waiting for a sentence start.
    end else if (hdr_pos != HP_BODY) begin
      if (byte_q == hdr_char(hdr_pos)) begin
        hdr_pos_next = hdr_pos + 3'd1;
        if (hdr_pos == HP_LAST) begin
          fld_next     = FLD_TIME;
          acc_next     = '0;
          seen_next    = '0;
          point_next   = 1'b0;
          stopped_next = 1'b0;
          cnt_next     = '0;
        end
      end else begin
        hdr_pos_next = HP_IDLE;
      end
    end else if (byte_q == ASCII_COMMA) begin
      case (fld)
        FLD_LAT:   held_lat_next   = finished[LAT_W-1:0];
        FLD_LON:   held_lon_next   = finished[LON_W-1:0];
        FLD_SPEED: held_knots_next = finished[KNOTS_W-1:0];
        FLD_TRACK: begin
          held_track_next = finished[TRACK_W-1:0];
          emit            = 1'b1;
          emit_fix        = 1'b1;
          hdr_pos_next    = HP_IDLE;
        end
        default: ;
      endcase
      if (fld != FLD_TRACK) begin
        fld_next     = fld + 3'd1;
        acc_next     = '0;
        seen_next    = '0;
        point_next   = 1'b0;
        stopped_next = 1'b0;
        cnt_next     = '0;
        // An empty direction field leaves its hemisphere at zero.
        if (fld == FLD_LAT) begin
          held_lat_hem_next = 8'h00;
        end
        if (fld == FLD_LON) begin
          held_lon_hem_next = 8'h00;
        end
      end
    end else if (fld == FLD_TIME) begin
      // The time field is skipped.
    end else if (fld == FLD_LATDIR || fld == FLD_LONDIR) begin
      // Only the first character of a direction field counts.
      if (cnt == '0) begin
        if (fld == FLD_LATDIR) begin
          held_lat_hem_next = byte_q;
        end else begin
          held_lon_hem_next = byte_q;
        end
        cnt_next = CW'(1);
      end
    end else if (cnt < CNT_MAX) begin
      cnt_next = cnt + 1'b1;
      if (fld == FLD_STATUS) begin
        // A void status ends the sentence with the held values.
        if (cnt == '0 && byte_q == ASCII_V) begin
          emit         = 1'b1;
          emit_fix     = 1'b0;
          hdr_pos_next = HP_IDLE;
        end
      end else if (!stopped) begin
        if (byte_q inside {[ASCII_ZERO:ASCII_NINE]}) begin
          // Extra fraction digits are dropped.
          if (!point || seen < frac_cur) begin
            acc_next = acc_digit;
            if (point) begin
              seen_next = seen + 3'd1;
            end
          end
        end else if (byte_q == ASCII_DOT && !point) begin
          point_next = 1'b1;
        end else begin
          stopped_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos      <= HP_IDLE;
      fld          <= FLD_TIME;
      acc          <= '0;
      seen         <= '0;
      point        <= 1'b0;
      stopped      <= 1'b0;
      cnt          <= '0;
      held_lat     <= '0;
      held_lat_hem <= '0;
      held_lon     <= '0;
      held_lon_hem <= '0;
      held_knots   <= '0;
      held_track   <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (advance) begin
        hdr_pos      <= hdr_pos_next;
        fld          <= fld_next;
        acc          <= acc_next;
        seen         <= seen_next;
        point        <= point_next;
        stopped      <= stopped_next;
        cnt          <= cnt_next;
        held_lat     <= held_lat_next;
        held_lat_hem <= held_lat_hem_next;
        held_lon     <= held_lon_next;
        held_lon_hem <= held_lon_hem_next;
        held_knots   <= held_knots_next;
        held_track   <= held_track_next;
      end
      if (advance && emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
    if (advance && emit) begin
      fix_valid      <= emit_fix;
      lat_value      <= held_lat_next;
      lat_hemisphere <= held_lat_hem_next;
      lon_value      <= held_lon_next;
      lon_hemisphere <= held_lon_hem_next;
      res_knots      <= held_knots_next;
      track_centideg <= held_track_next;
    end
  end

  // Thousandths of a knot times 1852 gives micro km/h; it fits 31 bits.
  assign speed_kmh_micro = SPEED_W'(res_knots) * SPEED_W'(SPEED_FACTOR);

`ifndef SYNTHESIS
  // The input side only stalls while a character is waiting in the input register.
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> byte_valid)
    else $error("rx stalled with an empty input register");

  // A result only comes out of the sentence body.
  a_emit_in_body: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && emit) |-> hdr_pos == HP_BODY)
    else $error("result emitted outside a sentence body");

  // A result that leaves the parse stage shows up on the port in the next cycle.
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> res_valid)
    else $error("emitted result was lost");

  // The accumulator and fraction counter stay within their limits.
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    (acc <= ACC_CAP) && (seen <= MAX_FRAC))
    else $error("number accumulator out of range");
`endif

endmodule
